// ----- sv/tlpq_pkg.sv -----
// Shared types and constants for the three-level priority byte queue.
// No dependencies; imported by every module of the block.
package tlpq_pkg;

  localparam logic       MODE_INSERT = 1'b0;
  localparam logic       MODE_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_NOT_LETTER = 2'd3;

  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_1    = 2'd1;
  localparam logic [1:0] LVL_2    = 2'd2;
  localparam logic [1:0] LVL_3    = 2'd3;

  localparam logic [7:0] EMPTY_BYTE = 8'd48;
  localparam logic [5:0] CAP_RESET  = 6'd49;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] level;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic       mode;
    logic [1:0] lvl;
    logic [7:0] data;
  } cmd_t;

endpackage

// ----- sv/tlpq_front.sv -----
// Front end: classifies each request byte into its priority level.
// Depends on tlpq_pkg; feeds tlpq_cmd_fifo.
module tlpq_front
  import tlpq_pkg::*;
(
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic push_valid,
  input  logic push_ready,
  output cmd_t push_cmd
);

  function automatic logic [1:0] classify(input logic [7:0] b);
    logic [1:0] lv;
    lv = LVL_NONE;
    if (b inside {[8'd65:8'd71], [8'd97:8'd103]}) begin
      lv = LVL_1;
    end else if (b inside {[8'd72:8'd79], [8'd104:8'd111]}) begin
      lv = LVL_2;
    end else if (b inside {[8'd80:8'd90], [8'd112:8'd122]}) begin
      lv = LVL_3;
    end
    return lv;
  endfunction

  assign push_valid    = req_valid;
  assign req_ready     = push_ready;
  assign push_cmd.mode = req.mode;
  assign push_cmd.lvl  = (req.mode == MODE_INSERT) ? classify(req.data_byte) : LVL_NONE;
  assign push_cmd.data = req.data_byte;

endmodule

// ----- sv/tlpq_cmd_fifo.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on tlpq_pkg for the command type.
module tlpq_cmd_fifo
  import tlpq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       ent [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = ent[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- sv/tlpq_back.sv -----
// Back end: level rings, head and fill pointers, capacity register, result register.
// Depends on tlpq_pkg; takes commands from tlpq_cmd_fifo.
module tlpq_back
  import tlpq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int LW = (FW > 6) ? FW : 6;
  localparam int MW = $clog2(3 * DEPTH);

  logic [7:0]    mem [0:3*DEPTH-1];
  logic [AW-1:0] head [0:2];
  logic [FW-1:0] fill [0:2];
  logic [5:0]    cap;
  logic [7:0]    rd_q;
  logic [1:0]    res_level;
  logic [1:0]    res_status;
  logic          res_mem;

  logic          take;
  logic [1:0]    sel;
  logic          any;
  logic [AW-1:0] sel_head;
  logic [FW-1:0] sel_fill;
  logic [LW-1:0] limit;
  logic          full;
  logic [FW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [MW-1:0] base;
  logic          do_write;
  logic          do_read;
  logic [MW-1:0] addr;
  logic [AW-1:0] head_next;
  logic [1:0]    level_next;
  logic [1:0]    status_next;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign take      = cmd_valid && cmd_ready;
  assign any       = (fill[0] != '0) || (fill[1] != '0) || (fill[2] != '0);

  always_comb begin
    if (cmd.mode == MODE_INSERT) begin
      sel = (cmd.lvl == LVL_NONE) ? 2'd0 : cmd.lvl - 2'd1;
    end else if (fill[0] != '0) begin
      sel = 2'd0;
    end else if (fill[1] != '0) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  assign sel_head = head[sel];
  assign sel_fill = fill[sel];
  assign limit    = (LW'(cap) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap);
  assign full     = LW'(sel_fill) >= limit;
  assign tail_sum = (FW+1)'(sel_head) + (FW+1)'(sel_fill);
  assign tail     = (tail_sum >= (FW+1)'(DEPTH)) ? AW'(tail_sum - (FW+1)'(DEPTH))
                                                : AW'(tail_sum);
  assign head_next = (sel_head == AW'(DEPTH - 1)) ? '0 : sel_head + AW'(1);

  always_comb begin
    case (sel)
      2'd0:    base = '0;
      2'd1:    base = MW'(DEPTH);
      default: base = MW'(2 * DEPTH);
    endcase
  end

  assign do_write = take && (cmd.mode == MODE_INSERT) && (cmd.lvl != LVL_NONE) && !full;
  assign do_read  = take && (cmd.mode == MODE_REMOVE) && any;
  assign addr     = base + MW'((cmd.mode == MODE_INSERT) ? tail : sel_head);

  always_comb begin
    if (cmd.mode == MODE_INSERT) begin
      level_next = cmd.lvl;
      if (cmd.lvl == LVL_NONE) begin
        status_next = ST_NOT_LETTER;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        status_next = ST_OK;
      end
    end else if (any) begin
      level_next  = sel + 2'd1;
      status_next = ST_OK;
    end else begin
      level_next  = LVL_NONE;
      status_next = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[addr] <= cmd.data;
    end
    if (do_read) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_level  <= level_next;
      res_status <= status_next;
      res_mem    <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_RESET;
      rsp_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (take) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (do_write) begin
        fill[sel] <= sel_fill + FW'(1);
      end
      if (do_read) begin
        head[sel] <= head_next;
        fill[sel] <= sel_fill - FW'(1);
      end
    end
  end

  assign rsp.out_byte = res_mem ? rd_q : EMPTY_BYTE;
  assign rsp.level    = res_level;
  assign rsp.status   = res_status;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill[0] <= FW'(DEPTH)) && (fill[1] <= FW'(DEPTH)) && (fill[2] <= FW'(DEPTH)))
    else $error("level fill exceeds ring depth");

  a_not_letter_level: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (res_status == ST_NOT_LETTER || res_status == ST_EMPTY)
      |-> (res_level == LVL_NONE) && !res_mem)
    else $error("rejected or empty result carries a level or byte");

  a_remove_ok: assert property (@(posedge clk) disable iff (rst)
    do_read |=> rsp_valid && res_mem && (res_status == ST_OK) && (res_level != LVL_NONE))
    else $error("remove from a filled level gave a bad result");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    take && (cmd.mode == MODE_REMOVE) && !any |=> (res_status == ST_EMPTY))
    else $error("remove from empty queues not flagged empty");

endmodule

// ----- sv/three_level_priority_queue_core.sv -----
// Three-level strict-priority byte queue, top level.
// Response: registered; valid in the cycle after its request leaves the command queue.
// Throughput: one request per cycle while responses are taken; the single ring port sets it.
// Reset: synchronous; clears pointers, fill counts and queues; capacity returns to 49.
// Ring contents are not cleared; depends on tlpq_pkg, tlpq_front, tlpq_cmd_fifo, tlpq_back.
module three_level_priority_queue_core
  import tlpq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  tlpq_front u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  tlpq_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  tlpq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd_valid(pop_valid),
    .cmd_ready(pop_ready),
    .cmd      (pop_cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

// ----- tb/tb_three_level_priority_queue_core.sv -----
// Self-checking testbench for three_level_priority_queue_core: directed table, then random phases.
// Predicts unchecked responses with its own three-ring priority queue; uses tlpq_pkg and the core.
`timescale 1ns / 100ps

module tb_three_level_priority_queue_core;
  import tlpq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int PHASES      = 13;
  localparam int PHASE_ITEMS = 140;
  localparam int CALM_PHASE  = 3;

  // negative capacity: pick one at random
  localparam int PHASE_CAP [PHASES]    = '{0, 1, 63, 63, 63, 1, 1, 2, 7, 49, 31, -1, 63};
  localparam int PHASE_REMOVE [PHASES] = '{30, 40, 15, 15, 15, 30, 90, 50, 35, 25, 60, 50, 70};

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       check;
    logic [7:0] out_byte;
    logic [1:0] level;
    logic [1:0] status;
  } stim_row_t;

  typedef struct packed {
    logic check;
    rsp_t want;
  } typed_rsp_t;

  localparam stim_row_t DIRECTED [24] = '{
    '{MODE_REMOVE, 8'hFF, 1'b1, EMPTY_BYTE, LVL_NONE, ST_EMPTY},
    '{MODE_INSERT, 8'd65, 1'b1, EMPTY_BYTE, LVL_1, ST_OK},
    '{MODE_INSERT, 8'd71, 1'b1, EMPTY_BYTE, LVL_1, ST_OK},
    '{MODE_INSERT, 8'd72, 1'b1, EMPTY_BYTE, LVL_2, ST_OK},
    '{MODE_INSERT, 8'd79, 1'b1, EMPTY_BYTE, LVL_2, ST_OK},
    '{MODE_INSERT, 8'd80, 1'b1, EMPTY_BYTE, LVL_3, ST_OK},
    '{MODE_INSERT, 8'd90, 1'b1, EMPTY_BYTE, LVL_3, ST_OK},
    '{MODE_INSERT, 8'd97, 1'b1, EMPTY_BYTE, LVL_1, ST_OK},
    '{MODE_INSERT, 8'd103, 1'b1, EMPTY_BYTE, LVL_1, ST_OK},
    '{MODE_INSERT, 8'd104, 1'b1, EMPTY_BYTE, LVL_2, ST_OK},
    '{MODE_INSERT, 8'd111, 1'b1, EMPTY_BYTE, LVL_2, ST_OK},
    '{MODE_INSERT, 8'd112, 1'b1, EMPTY_BYTE, LVL_3, ST_OK},
    '{MODE_INSERT, 8'd122, 1'b1, EMPTY_BYTE, LVL_3, ST_OK},
    '{MODE_INSERT, 8'd0, 1'b1, EMPTY_BYTE, LVL_NONE, ST_NOT_LETTER},
    '{MODE_INSERT, 8'd64, 1'b1, EMPTY_BYTE, LVL_NONE, ST_NOT_LETTER},
    '{MODE_INSERT, 8'd91, 1'b1, EMPTY_BYTE, LVL_NONE, ST_NOT_LETTER},
    '{MODE_INSERT, 8'd96, 1'b1, EMPTY_BYTE, LVL_NONE, ST_NOT_LETTER},
    '{MODE_INSERT, 8'd123, 1'b1, EMPTY_BYTE, LVL_NONE, ST_NOT_LETTER},
    '{MODE_INSERT, 8'd128, 1'b1, EMPTY_BYTE, LVL_NONE, ST_NOT_LETTER},
    '{MODE_INSERT, 8'd255, 1'b1, EMPTY_BYTE, LVL_NONE, ST_NOT_LETTER},
    '{MODE_REMOVE, 8'h00, 1'b0, 8'd0, LVL_NONE, ST_OK},
    '{MODE_REMOVE, 8'h55, 1'b0, 8'd0, LVL_NONE, ST_OK},
    '{MODE_REMOVE, 8'hAA, 1'b0, 8'd0, LVL_NONE, ST_OK},
    '{MODE_REMOVE, 8'hFF, 1'b0, 8'd0, LVL_NONE, ST_OK}
  };

  logic       clk = 1'b0;
  logic       rst;
  logic       req_valid;
  logic       req_ready;
  req_t       req;
  logic       rsp_valid;
  logic       rsp_ready;
  rsp_t       rsp;
  logic       cfg_we;
  logic [5:0] cfg_wdata;

  logic [7:0]  ring [3][DEPTH];
  int unsigned head [3];
  int unsigned fill [3];
  logic [5:0]  capacity;

  rsp_t        awaited_rsp [$];
  typed_rsp_t  typed_rsp [$];
  int unsigned requests_sent;
  int unsigned responses_seen;
  int unsigned errors;
  logic        calm;

  three_level_priority_queue_core #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [1:0] letter_level(input logic [7:0] b);
    if ((b >= 8'd65 && b < 8'd72) || (b >= 8'd97 && b < 8'd104)) return LVL_1;
    if ((b >= 8'd72 && b < 8'd80) || (b >= 8'd104 && b < 8'd112)) return LVL_2;
    if ((b >= 8'd80 && b <= 8'd90) || (b >= 8'd112 && b <= 8'd122)) return LVL_3;
    return LVL_NONE;
  endfunction

  function automatic rsp_t strict_priority_step(input req_t r);
    rsp_t        res;
    logic [1:0]  lv;
    int unsigned q;
    int unsigned limit;
    logic        found;
    res.out_byte = EMPTY_BYTE;
    res.level    = LVL_NONE;
    res.status   = ST_OK;
    if (r.mode == MODE_INSERT) begin
      lv = letter_level(r.data_byte);
      if (lv == LVL_NONE) begin
        res.status = ST_NOT_LETTER;
      end else begin
        q         = lv - 1;
        res.level = lv;
        limit     = (capacity > DEPTH) ? DEPTH : capacity;
        if (fill[q] >= limit) begin
          res.status = ST_FULL;
        end else begin
          ring[q][(head[q] + fill[q]) % DEPTH] = r.data_byte;
          fill[q]++;
        end
      end
    end else begin
      res.status = ST_EMPTY;
      found      = 1'b0;
      for (q = 0; q < 3; q++) begin
        if (!found && fill[q] != 0) begin
          found        = 1'b1;
          res.out_byte = ring[q][head[q]];
          res.level    = 2'(q + 1);
          res.status   = ST_OK;
          head[q]      = (head[q] + 1) % DEPTH;
          fill[q]--;
        end
      end
    end
    return res;
  endfunction

  function automatic req_t random_request(input int remove_pct);
    req_t r;
    r.mode = ($urandom_range(99) < remove_pct) ? MODE_REMOVE : MODE_INSERT;
    if ($urandom_range(4) == 0)
      r.data_byte = 8'($urandom_range(255));
    else
      r.data_byte = 8'(($urandom_range(1) ? 65 : 97) + $urandom_range(25));
    return r;
  endfunction

  task automatic send_request(input req_t r, input typed_rsp_t tr);
    while (!calm && $urandom_range(99) < 32) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    typed_rsp.push_back(tr);
    requests_sent++;
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    while (responses_seen != requests_sent) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [5:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity  = value;
  endtask

  always @(posedge clk) begin
    rsp_ready <= calm || ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    rsp_t       want;
    typed_rsp_t tr;
    if (!rst) begin
      if (req_valid && req_ready) begin
        want = strict_priority_step(req);
        tr   = typed_rsp.pop_front();
        if (tr.check)
          want = tr.want;
        awaited_rsp.push_back(want);
      end
      if (rsp_valid && rsp_ready) begin
        responses_seen++;
        if (awaited_rsp.size() == 0) begin
          errors++;
          $display("%0t: unexpected response byte %0d level %0d status %0d",
                   $realtime, rsp.out_byte, rsp.level, rsp.status);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp !== want) begin
            errors++;
            $display("%0t: expected byte/level/status %0d/%0d/%0d, actual %0d/%0d/%0d",
                     $realtime, want.out_byte, want.level, want.status,
                     rsp.out_byte, rsp.level, rsp.status);
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    req_t       r;
    typed_rsp_t tr;
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    calm           = 1'b0;
    requests_sent  = 0;
    capacity       = CAP_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      r.mode           = DIRECTED[i].mode;
      r.data_byte      = DIRECTED[i].data_byte;
      tr.check         = DIRECTED[i].check;
      tr.want.out_byte = DIRECTED[i].out_byte;
      tr.want.level    = DIRECTED[i].level;
      tr.want.status   = DIRECTED[i].status;
      send_request(r, tr);
    end
    drain_responses();

    for (int p = 0; p < PHASES; p++) begin
      calm <= (p == CALM_PHASE);
      write_capacity(PHASE_CAP[p] < 0 ? 6'($urandom_range(63)) : 6'(PHASE_CAP[p]));
      repeat (PHASE_ITEMS) send_request(random_request(PHASE_REMOVE[p]), '0);
      drain_responses();
    end

    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/tlpq_pkg.sv
sv/tlpq_front.sv
sv/tlpq_cmd_fifo.sv
sv/tlpq_back.sv
sv/three_level_priority_queue_core.sv
tb/tb_three_level_priority_queue_core.sv
